[hdl/chf_pkg.sv]
package chf_pkg;

   // fixed-point layout
   localparam int FRAC_BITS   = 14;
   localparam int CNT_W       = 9;
   localparam int SQRT_STEPS  = 15;
   localparam int CORDIC_STEPS = 24;

   localparam logic [14:0] ACTIVE_RESET = 15'd0;
   localparam logic [14:0] KNEE_RESET   = 15'd2860;
   localparam logic [14:0] INVSPAN_RESET = 15'd11734;

   // register indexes
   localparam logic [1:0] CSR_ACTIVE  = 2'd0;
   localparam logic [1:0] CSR_KNEE    = 2'd1;
   localparam logic [1:0] CSR_INVSPAN = 2'd2;

   // request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

   // controller to datapath
   typedef struct packed {
      logic             mem_we;
      logic             query_load;
      logic             scan_en;
      logic             scan_first;
      logic             round_en;
      logic             square_en;
      logic             sqrt_en;
      logic             cinit_en;
      logic             cordic_en;
      logic             angle_en;
      logic             mult_en;
      logic             out_load;
      logic             out_zero;
      logic [CNT_W-1:0] iter;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CNT_W-1:0] n_active;
      logic             rsp_full;
   } status_type;

   // truncated atan(2^-i) in Q2.30
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

[hdl/coverage_hole_floor.sv]
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   op, entry_index, dir_x, dir_y, dir_z
// rsp_      out        rsp_valid/rsp_stall   floor_level
// csr_      in         csr_we                csr_index, csr_data
//
// A query reads the active entries of the table one entry a cycle through a
// single memory port, then the square root and CORDIC iterate on shared units.
// A query with zero active entries skips the scan and returns a level of zero.
// Reset is synchronous; the table is not cleared and holds garbage until written.
// A held result waits in the output register; a new request is taken meanwhile.
module coverage_hole_floor #(
   parameter int MAX_SPEAKERS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [5:0]         req_entry_index,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_dir_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_floor_level,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);

   chf_pkg::cmd_type    cmd;
   chf_pkg::status_type status;

   chf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   chf_dp #(
      .MAX_SPEAKERS (MAX_SPEAKERS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_entry_index (req_entry_index),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_floor_level (rsp_floor_level),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

[hdl/chf_ctrl.sv]
module chf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   input  chf_pkg::status_type  status,
   output chf_pkg::cmd_type     cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_DRAIN  = 4'd2;
   localparam logic [3:0] S_ROUND  = 4'd3;
   localparam logic [3:0] S_SQUARE = 4'd4;
   localparam logic [3:0] S_SQRT   = 4'd5;
   localparam logic [3:0] S_CINIT  = 4'd6;
   localparam logic [3:0] S_CORDIC = 4'd7;
   localparam logic [3:0] S_ANGLE  = 4'd8;
   localparam logic [3:0] S_MULT   = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0]                  state_ff, state_in;
   logic [chf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        zero_ff, zero_in;
   logic                        out_go;

   assign req_stall = (state_ff != S_IDLE);
   assign out_go    = !status.rsp_full || !rsp_stall;

   // sequence one request
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      zero_in  = zero_ff;
      cmd      = '0;
      cmd.iter = cnt_ff;
      cmd.out_zero = zero_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == chf_pkg::OP_WRITE) begin
                  cmd.mem_we = 1'b1;
               end else begin
                  cmd.query_load = 1'b1;
                  cnt_in = '0;
                  if (status.n_active == '0) begin
                     zero_in  = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     zero_in  = 1'b0;
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            cmd.scan_en    = 1'b1;
            cmd.scan_first = (cnt_ff == '0);
            if (cnt_ff == status.n_active - 1'b1) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (cnt_ff == chf_pkg::CNT_W'(1)) begin
               state_in = S_ROUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square_en = 1'b1;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_en = 1'b1;
            if (cnt_ff == chf_pkg::CNT_W'(chf_pkg::SQRT_STEPS - 1)) begin
               state_in = S_CINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CINIT: begin
            cmd.cinit_en = 1'b1;
            cnt_in   = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_en = 1'b1;
            if (cnt_ff == chf_pkg::CNT_W'(chf_pkg::CORDIC_STEPS - 1)) begin
               state_in = S_ANGLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ANGLE: begin
            cmd.angle_en = 1'b1;
            state_in = S_MULT;
         end
         S_MULT: begin
            cmd.mult_en = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_go) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         zero_ff  <= zero_in;
      end
   end

endmodule

[hdl/chf_dp.sv]
module chf_dp #(
   parameter int MAX_SPEAKERS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [5:0]            req_entry_index,
   input  logic signed [15:0]    req_dir_x,
   input  logic signed [15:0]    req_dir_y,
   input  logic signed [15:0]    req_dir_z,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [14:0]           csr_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [14:0]           rsp_floor_level,
   input  chf_pkg::cmd_type      cmd,
   output chf_pkg::status_type   status
);

   localparam int AW = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
   localparam logic [chf_pkg::CNT_W-1:0] MAX_CNT = chf_pkg::CNT_W'(MAX_SPEAKERS);

   // configuration registers
   logic [6:0]  active_ff;
   logic [14:0] knee_ff, invspan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= chf_pkg::ACTIVE_RESET[6:0];
         knee_ff    <= chf_pkg::KNEE_RESET;
         invspan_ff <= chf_pkg::INVSPAN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            chf_pkg::CSR_ACTIVE:  active_ff  <= csr_data[6:0];
            chf_pkg::CSR_KNEE:    knee_ff    <= csr_data;
            chf_pkg::CSR_INVSPAN: invspan_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // saturate active count to table depth
   assign status.n_active = (chf_pkg::CNT_W'(active_ff) > MAX_CNT) ? MAX_CNT
                                                                    : chf_pkg::CNT_W'(active_ff);

   // direction table
   logic [47:0] mem [MAX_SPEAKERS];
   logic [47:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_we && (chf_pkg::CNT_W'(req_entry_index) < MAX_CNT)) begin
         mem[AW'(req_entry_index)] <= {req_dir_x, req_dir_y, req_dir_z};
      end
      if (cmd.scan_en) begin
         rdata_ff <= mem[cmd.iter[AW-1:0]];
      end
   end

   // hold query direction
   logic signed [15:0] qx_ff, qy_ff, qz_ff;
   always_ff @(posedge clock) begin
      if (cmd.query_load) begin
         qx_ff <= req_dir_x;
         qy_ff <= req_dir_y;
         qz_ff <= req_dir_z;
      end
   end

   // scan pipeline: read, multiply, sum and keep the maximum
   logic               rv_ff, rf_ff, pv_ff, pf_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [33:0] dot, best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         rv_ff <= cmd.scan_en;
         pv_ff <= rv_ff;
      end
   end

   assign dot = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);

   always_ff @(posedge clock) begin
      rf_ff <= cmd.scan_first;
      pf_ff <= rf_ff;
      px_ff <= qx_ff * $signed(rdata_ff[47:32]);
      py_ff <= qy_ff * $signed(rdata_ff[31:16]);
      pz_ff <= qz_ff * $signed(rdata_ff[15:0]);
      if (pv_ff && (pf_ff || dot > best_ff)) begin
         best_ff <= dot;
      end
   end

   // clamp and round the best cosine to Q.14
   localparam logic signed [33:0] ONE2 = 34'sd268435456;
   logic signed [33:0] best_cl, best_off;
   logic signed [15:0] c_ff;

   always_comb begin
      best_cl = best_ff;
      if (best_ff > ONE2)  best_cl = ONE2;
      if (best_ff < -ONE2) best_cl = -ONE2;
      best_off = best_cl + ONE2 + 34'sd8192;
   end

   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         c_ff <= 16'(best_off >>> chf_pkg::FRAC_BITS) - 16'sd16384;
      end
   end

   // integer square root of one minus cosine squared, one digit a cycle
   logic [29:0]        rem_ff, res_ff, bit_ff;
   logic [29:0]        trial;
   logic signed [31:0] csq;

   assign csq   = c_ff * c_ff;
   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.square_en) begin
         rem_ff <= 30'(32'sd268435456 - csq);
         res_ff <= '0;
         bit_ff <= 30'd268435456;
      end else if (cmd.sqrt_en) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // CORDIC vectoring, one rotation a cycle
   logic signed [34:0] x_ff, y_ff, xs, ys;
   logic signed [32:0] z_ff, atan_s;
   logic [15:0]        ac;

   assign ac     = c_ff[15] ? 16'(-c_ff) : c_ff;
   assign xs     = x_ff >>> cmd.iter[4:0];
   assign ys     = y_ff >>> cmd.iter[4:0];
   assign atan_s = $signed({1'b0, chf_pkg::atan_q30(cmd.iter[4:0])});

   always_ff @(posedge clock) begin
      if (cmd.cinit_en) begin
         x_ff <= $signed({3'b000, ac, 16'h0000});
         y_ff <= $signed({4'b0000, res_ff[14:0], 16'h0000});
         z_ff <= '0;
      end else if (cmd.cordic_en) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_s;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_s;
         end
      end
   end

   // fold angle into [0, pi] and round to Q.14
   logic signed [33:0] zc, zq;
   logic [16:0]        a_ff;

   always_comb begin
      zc = 34'(z_ff);
      if (zc < 0)           zc = '0;
      if (zc > chf_pkg::HALF_PI_Q30) zc = chf_pkg::HALF_PI_Q30;
      zq = c_ff[15] ? (chf_pkg::PI_Q30 - zc) : zc;
   end

   always_ff @(posedge clock) begin
      if (cmd.angle_en) begin
         a_ff <= 17'((zq + 34'sd32768) >>> 16);
      end
   end

   // scale above the knee
   logic signed [17:0] diff;
   logic signed [33:0] f_ff;

   assign diff = $signed({1'b0, a_ff}) - $signed({3'b000, knee_ff});

   always_ff @(posedge clock) begin
      if (cmd.mult_en) begin
         f_ff <= diff * $signed({1'b0, invspan_ff});
      end
   end

   // round, saturate and register the result
   logic signed [33:0] f_rnd;
   logic [14:0]        level;
   logic               valid_ff;
   logic [14:0]        level_ff;

   always_comb begin
      f_rnd = (f_ff + 34'sd8192) >>> chf_pkg::FRAC_BITS;
      if (cmd.out_zero || f_ff <= 0) begin
         level = '0;
      end else if (f_rnd > 34'sd16384) begin
         level = 15'd16384;
      end else begin
         level = f_rnd[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         level_ff <= level;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_floor_level = level_ff;
   assign status.rsp_full = valid_ff;

endmodule

[hdl/chf_checker.sv]
module chf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_floor_level
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_floor_level))
      else $error("stalled result changed");

   // result never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_floor_level <= 15'd16384)
      else $error("floor level above one");

   // a table write makes no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == chf_pkg::OP_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("result after a write request");

   // an accepted query makes the block busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == chf_pkg::OP_QUERY |=> req_stall)
      else $error("query accepted without going busy");

endmodule

bind coverage_hole_floor chf_checker u_chf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_op          (req_op),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_floor_level (rsp_floor_level)
);
